FILE: design/pca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pca_pkg;

  // Command codes on in_cmd
  localparam logic [2:0] CMD_LOAD_MEAN  = 3'd0;
  localparam logic [2:0] CMD_LOAD_BASIS = 3'd1;
  localparam logic [2:0] CMD_CLEAR      = 3'd2;
  localparam logic [2:0] CMD_PROJECT    = 3'd3;
  localparam logic [2:0] CMD_RECON      = 3'd4;

  localparam int ELEM_W     = 12;
  localparam int VALUE_W    = 17;
  localparam int COMP_W     = 4;
  localparam int NCOMP_W    = 5;
  localparam int MEAN_W     = 16;
  localparam int BASIS_W    = 16;
  localparam int PIX_W      = 8;
  localparam int DIFF_W     = 18;
  localparam int ACC_W      = 48;
  localparam int HALF_W     = 24;
  localparam int PROD_W     = 64;
  localparam int TERM_SHIFT = 30;
  localparam int TERM_W     = PROD_W - TERM_SHIFT;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_FIN,
    ST_SUM,
    ST_PUSH
  } state_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic rd_en;   // read basis at the shared address
    logic clear;   // zero the weight
    logic part;    // weight x basis partial products
    logic full;    // combine into the full product
    logic fin;     // accumulate (project) or round to a term (reconstruct)
    logic proj;    // current item is a projection
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/pca_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/pca_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pca_cell #(
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int SUM_W = 40
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pca_pkg::cell_ctl_t                  ctl,
  input  logic                                term_en,
  input  logic                                wr_en,
  input  logic [AW-1:0]                       addr,
  input  logic [pca_pkg::BASIS_W-1:0]         wr_data,
  input  logic signed [pca_pkg::DIFF_W-1:0]   diff,
  input  logic                                sum_in_valid,
  input  logic signed [SUM_W-1:0]             sum_in,
  output logic                                sum_out_valid,
  output logic signed [SUM_W-1:0]             sum_out
);

  import pca_pkg::*;

  localparam logic signed [PROD_W-1:0] RND = PROD_W'(64'd1 << (TERM_SHIFT - 1));

  logic [BASIS_W-1:0]                 basis_q;
  logic signed [BASIS_W-1:0]          b;
  logic signed [HALF_W:0]             acc_lo;
  logic signed [HALF_W-1:0]           acc_hi;
  logic signed [ACC_W-1:0]            acc_r;
  logic signed [HALF_W+BASIS_W:0]     lo_r;
  logic signed [HALF_W+BASIS_W-1:0]   hi_r;
  logic signed [DIFF_W+BASIS_W-1:0]   dprod;
  logic signed [PROD_W-1:0]           ex_nxt;
  logic signed [PROD_W-1:0]           ex_r;
  logic signed [PROD_W-1:0]           rnd;
  logic signed [TERM_W-1:0]           term_r;
  logic                               sum_valid_r;
  logic signed [SUM_W-1:0]            sum_r;

  pca_ram #(
    .WIDTH (BASIS_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_basis (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (addr),
    .rd_data (basis_q)
  );

  assign b      = $signed(basis_q);
  assign acc_lo = $signed({1'b0, acc_r[HALF_W-1:0]});
  assign acc_hi = acc_r[ACC_W-1:HALF_W];
  assign dprod  = diff * b;

  always_comb begin
    if (ctl.proj) begin
      ex_nxt = PROD_W'(dprod);
    end else begin
      ex_nxt = $signed({hi_r, {HALF_W{1'b0}}}) + PROD_W'(lo_r);
    end
  end

  // round to Q.8: add half an LSB, then floor
  assign rnd = ex_r + RND;

  always_ff @(posedge clk) begin
    if (ctl.part) begin
      lo_r <= acc_lo * b;
      hi_r <= acc_hi * b;
    end
    if (ctl.full) begin
      ex_r <= ex_nxt;
    end
    if (ctl.fin && !ctl.proj) begin
      term_r <= rnd[PROD_W-1:TERM_SHIFT];
    end
    if (sum_in_valid) begin
      sum_r <= sum_in + (term_en ? SUM_W'(term_r) : SUM_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      sum_valid_r <= 1'b0;
    end else begin
      sum_valid_r <= sum_in_valid;
      if (ctl.clear) begin
        acc_r <= '0;
      end else if (ctl.fin && ctl.proj) begin
        acc_r <= acc_r + ex_r[ACC_W-1:0];
      end
    end
  end

  assign sum_out_valid = sum_valid_r;
  assign sum_out       = sum_r;

endmodule

`default_nettype wire

FILE: design/pca_project_reconstruct.sv
`timescale 1ns / 1ps
`default_nettype none

// PCA projection / reconstruction engine, one cell per component.
// Input channel (in_valid/in_ready) carries commands: load mean, load basis,
// clear weights, project pixel, reconstruct element. Only reconstruct gives
// a result, on the out_ channel (out_valid/out_ready).
// cfg_ channel writes num_components; it is always ready. It must be written
// only while the block is idle; the block itself does not enforce this.
// Items are taken one at a time. Loads and clear finish on transfer. A
// projection goes through memory read, difference, multiply, accumulate.
// A reconstruct goes from transfer to out_valid through read, partial
// products, full product, rounding, then the partial sum walks the cell
// chain one cell per cycle, then saturation.
// The finished result sits in an output register; the next item is taken
// while it waits. A further reconstruct result is held in the block until
// the output register is free, and no new item is taken meanwhile.
// Reset clears the weights, num_components and the handshake state. Mean
// and basis memories hold no reset value and must be loaded before use.
module pca_project_reconstruct #(
  parameter int NUM_ELEMENTS   = 4096,
  parameter int MAX_COMPONENTS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_cmd,
  input  logic [pca_pkg::COMP_W-1:0]          in_component,
  input  logic [pca_pkg::ELEM_W-1:0]          in_element,
  input  logic signed [pca_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pca_pkg::ELEM_W-1:0]          out_element,
  output logic [15:0]                         out_value,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pca_pkg::NCOMP_W-1:0]         cfg_num_components
);

  import pca_pkg::*;

  localparam int AW    = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int SUM_W = TERM_W + 1 + $clog2(MAX_COMPONENTS + 1);
  localparam logic signed [SUM_W-1:0] VAL_MAX = SUM_W'(65535);

  state_t                    state_r, state_nxt;
  logic                      in_xfer;
  logic                      elem_ok;
  logic [ELEM_W+AW-1:0]      elem_ext;
  logic [AW-1:0]             addr;
  logic                      mean_we;
  logic                      rd_go;
  logic [PIX_W-1:0]          pix_nxt;
  logic [MEAN_W-1:0]         mean_q;
  logic [NCOMP_W-1:0]        num_comp_r;
  logic [ELEM_W-1:0]         elem_r;
  logic                      proj_r;
  logic [PIX_W-1:0]          pix_r;
  logic [MEAN_W-1:0]         mean_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic                      inject_r;
  logic [15:0]               pend_value_r;
  logic                      pend_sat_r;
  logic                      out_valid_r;
  logic [ELEM_W-1:0]         out_element_r;
  logic [15:0]               out_value_r;
  logic                      out_sat_r;
  logic                      push;
  logic [15:0]               sat_value;
  logic                      sat_flag;
  cell_ctl_t                 ctl;
  logic                      chain_valid [MAX_COMPONENTS];
  logic signed [SUM_W-1:0]   chain_sum   [MAX_COMPONENTS];
  logic signed [SUM_W-1:0]   last_sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign elem_ok   = 32'(in_element) < NUM_ELEMENTS;
  assign elem_ext  = {{AW{1'b0}}, in_element};
  assign addr      = elem_ext[AW-1:0];
  assign mean_we   = in_xfer && (in_cmd == CMD_LOAD_MEAN) && elem_ok;
  assign rd_go     = in_xfer && elem_ok && ((in_cmd == CMD_PROJECT) || (in_cmd == CMD_RECON));

  always_comb begin
    if (in_value < 17'sd0) begin
      pix_nxt = '0;
    end else if (in_value > 17'sd255) begin
      pix_nxt = '1;
    end else begin
      pix_nxt = in_value[PIX_W-1:0];
    end
  end

  pca_ram #(
    .WIDTH (MEAN_W),
    .DEPTH (NUM_ELEMENTS),
    .AW    (AW)
  ) u_mean (
    .clk     (clk),
    .wr_en   (mean_we),
    .wr_addr (addr),
    .wr_data (in_value[MEAN_W-1:0]),
    .rd_en   (rd_go),
    .rd_addr (addr),
    .rd_data (mean_q)
  );

  assign ctl.rd_en = rd_go;
  assign ctl.clear = in_xfer && (in_cmd == CMD_CLEAR);
  assign ctl.part  = (state_r == ST_READ);
  assign ctl.full  = (state_r == ST_MUL);
  assign ctl.fin   = (state_r == ST_FIN);
  assign ctl.proj  = proj_r;

  for (genvar c = 0; c < MAX_COMPONENTS; c++) begin : g_cell
    logic                    basis_we;
    logic                    term_en;
    logic                    cin_valid;
    logic signed [SUM_W-1:0] cin_sum;

    assign basis_we = in_xfer && (in_cmd == CMD_LOAD_BASIS) && elem_ok &&
                      (32'(in_component) == c);
    assign term_en  = 32'(num_comp_r) > c;

    if (c == 0) begin : g_head
      assign cin_valid = inject_r;
      assign cin_sum   = SUM_W'($signed({1'b0, mean_r}));
    end else begin : g_link
      assign cin_valid = chain_valid[c-1];
      assign cin_sum   = chain_sum[c-1];
    end

    pca_cell #(
      .DEPTH (NUM_ELEMENTS),
      .AW    (AW),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .term_en       (term_en),
      .wr_en         (basis_we),
      .addr          (addr),
      .wr_data       (in_value[BASIS_W-1:0]),
      .diff          (diff_r),
      .sum_in_valid  (cin_valid),
      .sum_in        (cin_sum),
      .sum_out_valid (chain_valid[c]),
      .sum_out       (chain_sum[c])
    );
  end

  assign last_sum = chain_sum[MAX_COMPONENTS-1];

  always_comb begin
    if (last_sum < 0) begin
      sat_value = '0;
      sat_flag  = 1'b1;
    end else if (last_sum > VAL_MAX) begin
      sat_value = '1;
      sat_flag  = 1'b1;
    end else begin
      sat_value = last_sum[15:0];
      sat_flag  = 1'b0;
    end
  end

  assign push = (state_r == ST_PUSH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_cmd)
            CMD_PROJECT: if (elem_ok) state_nxt = ST_READ;
            CMD_RECON:   state_nxt = elem_ok ? ST_READ : ST_PUSH;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = proj_r ? ST_IDLE : ST_SUM;
      ST_SUM: begin
        if (chain_valid[MAX_COMPONENTS-1]) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (push) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_comp_r  <= '0;
      inject_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      inject_r <= (state_r == ST_FIN) && !proj_r;
      if (cfg_valid) begin
        num_comp_r <= cfg_num_components;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      elem_r       <= in_element;
      proj_r       <= (in_cmd == CMD_PROJECT);
      pix_r        <= pix_nxt;
      // out-of-range reconstruct answers zero
      pend_value_r <= '0;
      pend_sat_r   <= 1'b0;
    end
    if (state_r == ST_READ) begin
      mean_r <= mean_q;
      diff_r <= $signed({2'b00, pix_r, 8'h00}) - $signed({2'b00, mean_q});
    end
    if ((state_r == ST_SUM) && chain_valid[MAX_COMPONENTS-1]) begin
      pend_value_r <= sat_value;
      pend_sat_r   <= sat_flag;
    end
    if (push) begin
      out_element_r <= elem_r;
      out_value_r   <= pend_value_r;
      out_sat_r     <= pend_sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_element   = out_element_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire
